[hdl/cnalu_pkg.sv]
// shared types and codes for the complex arithmetic unit
package cnalu_pkg;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_SCALE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } status_t;

    typedef struct packed {
        logic neg;
        logic ovf;
    } div_flags_t;

endpackage

[hdl/cnalu_div.sv]
// pipelined restoring divider, one quotient bit per stage
module cnalu_div #(
    parameter int DW = 16,
    parameter int F  = 8
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic                    neg_in,
    input  logic [2*DW:0]           mag_in,
    input  logic [2*DW:0]           den_in,
    output logic [DW:0]             q_out,
    output cnalu_pkg::div_flags_t   flags_out
);
    import cnalu_pkg::*;

    localparam int MW = 2 * DW + 1;
    localparam int QB = DW + 1;
    localparam int CW = MW + F + QB + 1;

    logic [CW-1:0] rem_reg [0:QB];
    logic [MW-1:0] den_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    div_flags_t    flg_reg [0:QB];

    logic [CW-1:0] rem0_next;

    assign rem0_next = CW'(mag_in) << F;

    // prescale and range check: quotient too wide means saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]     <= rem0_next;
            den_reg[0]     <= den_in;
            q_reg[0]       <= '0;
            flg_reg[0].neg <= neg_in;
            flg_reg[0].ovf <= (rem0_next >= (CW'(den_in) << QB));
        end
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_stage
        localparam int K = QB - i;
        logic [CW-1:0] dsh;
        logic          take;

        assign dsh  = CW'(den_reg[i-1]) << K;
        assign take = (rem_reg[i-1] >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? (rem_reg[i-1] - dsh) : rem_reg[i-1];
                den_reg[i] <= den_reg[i-1];
                q_reg[i]   <= q_reg[i-1] | (QB'(take) << K);
                flg_reg[i] <= flg_reg[i-1];
            end
        end
    end

    assign q_out     = q_reg[QB];
    assign flags_out = flg_reg[QB];

endmodule

[hdl/complex_number_alu_core.sv]
// top level of the pipelined complex arithmetic unit
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, command, a_*, b_*    | in (stall out)
//  output  | out_valid, out_stall, res_re/im, status  | out (stall in)
//
// one word enters per cycle unless the pipe is stalled; it then passes the input,
// product, sum and operand stages, the divider (a prescale stage plus one
// quotient bit per stage, 17 at 16 bits) and the output reg
// reset clears only the valid bits; payload registers are not reset
// a stalled result freezes the whole pipeline, so nothing is lost or repeated
// in_stall is raised only while a finished word waits and out_stall is high
module complex_number_alu_core #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   command,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output logic [1:0]                   status
);
    import cnalu_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW;        // product width
    localparam int SW = 2 * DW + 2;    // sum width
    localparam int MW = 2 * DW + 1;    // magnitude / denominator width
    localparam int QB = DW + 1;        // quotient bits
    localparam int L  = QB + 1;        // divider register stages

    localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic [QB-1:0] QPOS = {2'b00, {(DW-1){1'b1}}};
    localparam logic [QB-1:0] QNEG = {2'b01, {(DW-1){1'b0}}};

    typedef struct packed {
        logic          is_div;
        logic          dz;
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic [1:0]    st;
    } side_t;

    // global advance: the pipe moves unless the output word is held
    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // saturate a signed sum to DW bits, msb of result is the clip flag
    function automatic logic [DW:0] clip_s(input logic signed [SW-1:0] x);
        logic [DW:0] r;
        if (x > SMAX)
            r = {1'b1, SMAX[DW-1:0]};
        else if (x < SMIN)
            r = {1'b1, SMIN[DW-1:0]};
        else
            r = {1'b0, x[DW-1:0]};
        return r;
    endfunction

    // saturate a sign/magnitude quotient
    function automatic logic [DW:0] clip_q(input logic neg, input logic ovf,
                                           input logic [QB-1:0] q);
        logic [DW:0]   r;
        logic [QB-1:0] nq;
        nq = -q;
        if (!neg)
            r = (ovf || q > QPOS) ? {1'b1, QPOS[DW-1:0]} : {1'b0, q[DW-1:0]};
        else if (q == '0)
            r = '0;
        else
            r = (ovf || q > QNEG) ? {1'b1, QNEG[DW-1:0]} : {1'b0, nq[DW-1:0]};
        return r;
    endfunction

    // stage 1: input register
    logic                 v1_reg;
    logic [2:0]           cmd1_reg;
    logic signed [DW-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg <= command;
            ar1_reg  <= a_re;
            ai1_reg  <= a_im;
            br1_reg  <= b_re;
            bi1_reg  <= b_im;
        end
    end

    // stage 2: all six products in parallel
    logic                 v2_reg;
    logic [2:0]           cmd2_reg;
    logic signed [DW-1:0] ar2_reg, ai2_reg, br2_reg, bi2_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg, pbb_reg, pcc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd2_reg <= cmd1_reg;
            ar2_reg  <= ar1_reg;
            ai2_reg  <= ai1_reg;
            br2_reg  <= br1_reg;
            bi2_reg  <= bi1_reg;
            prr_reg  <= ar1_reg * br1_reg;
            pii_reg  <= ai1_reg * bi1_reg;
            pri_reg  <= ar1_reg * bi1_reg;
            pir_reg  <= ai1_reg * br1_reg;
            pbb_reg  <= br1_reg * br1_reg;
            pcc_reg  <= bi1_reg * bi1_reg;
        end
    end

    // stage 3: exact sums per command, divisor energy
    logic                 v3_reg;
    logic [2:0]           cmd3_reg;
    logic signed [SW-1:0] sre3_reg, sim3_reg;
    logic [MW-1:0]        den3_reg;
    logic signed [SW-1:0] sre_next, sim_next;

    always_comb
    begin
        case (cmd2_reg)
            CMD_ADD:
            begin
                sre_next = SW'(ar2_reg) + SW'(br2_reg);
                sim_next = SW'(ai2_reg) + SW'(bi2_reg);
            end
            CMD_SUB:
            begin
                sre_next = SW'(ar2_reg) - SW'(br2_reg);
                sim_next = SW'(ai2_reg) - SW'(bi2_reg);
            end
            CMD_MUL:
            begin
                sre_next = SW'(prr_reg) - SW'(pii_reg);
                sim_next = SW'(pri_reg) + SW'(pir_reg);
            end
            CMD_DIV:
            begin
                sre_next = SW'(prr_reg) + SW'(pii_reg);
                sim_next = SW'(pir_reg) - SW'(pri_reg);
            end
            CMD_SCALE:
            begin
                sre_next = SW'(prr_reg);
                sim_next = SW'(pir_reg);
            end
            default:
            begin
                sre_next = '0;
                sim_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd3_reg <= cmd2_reg;
            sre3_reg <= sre_next;
            sim3_reg <= sim_next;
            den3_reg <= MW'(pbb_reg) + MW'(pcc_reg);
        end
    end

    // stage 4: finish the non-divide results, form divider operands
    logic [DW:0]          cre, cim;
    side_t                side0_next;
    logic signed [SW-1:0] are_abs, aim_abs;

    always_comb
    begin
        case (cmd3_reg)
            CMD_ADD, CMD_SUB:
            begin
                cre = clip_s(sre3_reg);
                cim = clip_s(sim3_reg);
            end
            CMD_MUL, CMD_SCALE:
            begin
                // arithmetic shift gives the floor
                cre = clip_s(sre3_reg >>> FRAC_BITS);
                cim = clip_s(sim3_reg >>> FRAC_BITS);
            end
            default:
            begin
                cre = '0;
                cim = '0;
            end
        endcase
        side0_next.is_div = (cmd3_reg == CMD_DIV);
        side0_next.dz     = (den3_reg == '0);
        side0_next.re     = cre[DW-1:0];
        side0_next.im     = cim[DW-1:0];
        side0_next.st     = (cre[DW] || cim[DW]) ? ST_SAT : ST_OK;
        are_abs = sre3_reg[SW-1] ? -sre3_reg : sre3_reg;
        aim_abs = sim3_reg[SW-1] ? -sim3_reg : sim3_reg;
    end

    logic          nre4_reg, nim4_reg;
    logic [MW-1:0] mre4_reg, mim4_reg, den4_reg;
    logic          side_v_reg [0:L];
    side_t         side_reg   [0:L];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nre4_reg <= sre3_reg[SW-1];
            nim4_reg <= sim3_reg[SW-1];
            mre4_reg <= are_abs[MW-1:0];
            mim4_reg <= aim_abs[MW-1:0];
            den4_reg <= den3_reg;
        end
    end

    // side data rides alongside the divider; only the valid bits are reset
    for (genvar j = 0; j <= L; j++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_v_reg[j] <= 1'b0;
            else if (en)
                side_v_reg[j] <= (j == 0) ? v3_reg : side_v_reg[(j == 0) ? 0 : j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[j] <= (j == 0) ? side0_next : side_reg[(j == 0) ? 0 : j-1];
        end
    end

    // one divider per component, sharing the divisor
    logic [QB-1:0] qre, qim;
    div_flags_t    fre, fim;

    cnalu_div #(.DW(DW), .F(FRAC_BITS)) u_div_re (
        .clk       (clk),
        .en        (en),
        .neg_in    (nre4_reg),
        .mag_in    (mre4_reg),
        .den_in    (den4_reg),
        .q_out     (qre),
        .flags_out (fre)
    );

    cnalu_div #(.DW(DW), .F(FRAC_BITS)) u_div_im (
        .clk       (clk),
        .en        (en),
        .neg_in    (nim4_reg),
        .mag_in    (mim4_reg),
        .den_in    (den4_reg),
        .q_out     (qim),
        .flags_out (fim)
    );

    // output stage: pick divider or carried result
    logic [DW:0]   dre, dim;
    logic [DW-1:0] ore_next, oim_next;
    logic [1:0]    ost_next;

    always_comb
    begin
        dre = clip_q(fre.neg, fre.ovf, qre);
        dim = clip_q(fim.neg, fim.ovf, qim);
        if (!side_reg[L].is_div)
        begin
            ore_next = side_reg[L].re;
            oim_next = side_reg[L].im;
            ost_next = side_reg[L].st;
        end
        else if (side_reg[L].dz)
        begin
            ore_next = '0;
            oim_next = '0;
            ost_next = ST_DZ;
        end
        else
        begin
            ore_next = dre[DW-1:0];
            oim_next = dim[DW-1:0];
            ost_next = (dre[DW] || dim[DW]) ? ST_SAT : ST_OK;
        end
    end

    logic          ov_reg;
    logic [DW-1:0] ore_reg, oim_reg;
    logic [1:0]    ost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= side_v_reg[L];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ore_reg <= ore_next;
            oim_reg <= oim_next;
            ost_reg <= ost_next;
        end
    end

    assign out_valid = ov_reg;
    assign res_re    = ore_reg;
    assign res_im    = oim_reg;
    assign status    = ost_reg;

endmodule
